// ===== rtl/graph_coloring_enumerator_top_defines.svh =====
// Assertion macros for the colouring enumerator.
`ifndef GRAPH_COLORING_ENUMERATOR_TOP_DEFINES_SVH
`define GRAPH_COLORING_ENUMERATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Implication in the same cycle.
`define GCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication into the next cycle.
`define GCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GCE_ASSERT_NOW(lbl, ante, cons, msg)
`define GCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/gce_pkg.sv =====
package gce_pkg;

  localparam int unsigned CountW   = 23;
  localparam int unsigned ColoringW = 24;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Request kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_FIND    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ACK       = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_row;   // write one adjacency row
    logic restart;    // clear colours, depth, flag and count
    logic ack;        // reply with an acknowledge word
    logic reply_exh;  // reply exhausted without searching
    logic resume;     // pick the vertex to resume from
    logic enter;      // open the current vertex: candidate after its colour, clear colour
    logic place_fwd;  // place candidate, move down one vertex
    logic place_fin;  // place candidate on the last vertex, count, reply found
    logic retreat;    // move back one vertex
    logic give_up;    // mark exhausted, reply exhausted
    logic next_col;   // try the next colour
  } gce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exhausted;
    logic cand_over;  // candidate above the colour count
    logic allowed;    // candidate clashes with no neighbour
    logic d_zero;
    logic d_last;
  } gce_stat_t;

endpackage

// ===== rtl/gce_ctrl.sv =====
module gce_ctrl
  import gce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic [1:0] kind_i,
  input  gce_stat_t stat_i,
  output logic      busy,
  output gce_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ENTER = 2'd1;
  localparam logic [1:0] S_TRY   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (kind_i)
            KIND_LOAD: begin
              cmd_o.load_row = 1'b1;
              cmd_o.ack      = 1'b1;
            end
            KIND_RESTART: begin
              cmd_o.restart = 1'b1;
              cmd_o.ack     = 1'b1;
            end
            KIND_FIND: begin
              if (stat_i.exhausted) begin
                cmd_o.reply_exh = 1'b1;
              end else begin
                cmd_o.resume = 1'b1;
                state_d      = S_ENTER;
              end
            end
            default: cmd_o.ack = 1'b1;
          endcase
        end
      end
      S_ENTER: begin
        cmd_o.enter = 1'b1;
        state_d     = S_TRY;
      end
      S_TRY: begin
        priority if (stat_i.cand_over) begin
          if (stat_i.d_zero) begin
            cmd_o.give_up = 1'b1;
            state_d       = S_IDLE;
          end else begin
            cmd_o.retreat = 1'b1;
            state_d       = S_ENTER;
          end
        end else if (stat_i.allowed) begin
          if (stat_i.d_last) begin
            cmd_o.place_fin = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.place_fwd = 1'b1;
            state_d         = S_ENTER;
          end
        end else begin
          cmd_o.next_col = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/gce_dp.sv =====
module gce_dp
  import gce_pkg::*;
#(
  parameter int unsigned VERTICES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gce_cmd_t             cmd_i,
  input  logic [2:0]           vertex_i,
  input  logic [7:0]           neighbours_i,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_data_i,
  output gce_stat_t            stat_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ColoringW-1:0] coloring_o,
  output logic [CountW-1:0]    solution_count_o
);

  localparam int unsigned IW = $clog2(VERTICES);
  localparam int unsigned DW = $clog2(VERTICES + 1);

  logic [VERTICES-1:0] adj_q [VERTICES];
  logic [2:0]          vc_q  [VERTICES];
  logic [2:0]          vc_d  [VERTICES];
  logic [IW-1:0]       d_q, d_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic                exh_q, exh_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [3:0]          cand_q, cand_d;
  logic [2:0]          color_count_q;
  logic                done_q;
  logic [1:0]          status_q;
  logic [ColoringW-1:0] coloring_q, packed_d;
  logic                respond;
  logic                clash;
  logic                row_ok;

  assign row_ok  = ({1'b0, vertex_i} < 4'(VERTICES));
  assign respond = cmd_i.ack | cmd_i.reply_exh | cmd_i.place_fin | cmd_i.give_up;

  // Candidate against every neighbour of the current vertex at once.
  always_comb begin
    clash = 1'b0;
    for (int k = 0; k < VERTICES; k++) begin
      if (adj_q[d_q][k] && ({1'b0, vc_q[k]} == cand_q)) clash = 1'b1;
    end
  end

  assign stat_o.exhausted = exh_q;
  assign stat_o.cand_over = (cand_q > {1'b0, color_count_q});
  assign stat_o.allowed   = !clash;
  assign stat_o.d_zero    = (d_q == '0);
  assign stat_o.d_last    = (d_q == IW'(VERTICES - 1));

  always_comb begin
    vc_d    = vc_q;
    d_d     = d_q;
    depth_d = depth_q;
    exh_d   = exh_q;
    count_d = count_q;
    cand_d  = cand_q;
    if (cmd_i.restart) begin
      for (int k = 0; k < VERTICES; k++) vc_d[k] = '0;
      depth_d = '0;
      exh_d   = 1'b0;
      count_d = '0;
    end
    if (cmd_i.resume) begin
      d_d = (depth_q >= DW'(VERTICES)) ? IW'(VERTICES - 1) : depth_q[IW-1:0];
    end
    if (cmd_i.enter) begin
      cand_d     = {1'b0, vc_q[d_q]} + 4'd1;
      vc_d[d_q]  = '0;
    end
    if (cmd_i.next_col) cand_d = cand_q + 4'd1;
    if (cmd_i.place_fwd || cmd_i.place_fin) vc_d[d_q] = cand_q[2:0];
    if (cmd_i.place_fwd) d_d = d_q + IW'(1);
    if (cmd_i.retreat) d_d = d_q - IW'(1);
    if (cmd_i.place_fin) begin
      depth_d = DW'(VERTICES);
      if (count_q != CountMax) count_d = count_q + CountW'(1);
    end
    if (cmd_i.give_up) begin
      depth_d = '0;
      exh_d   = 1'b1;
    end
  end

  always_comb begin
    packed_d = '0;
    for (int k = 0; k < VERTICES; k++) packed_d[3*k +: 3] = vc_d[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VERTICES; k++) begin
        adj_q[k] <= '0;
        vc_q[k]  <= '0;
      end
      d_q           <= '0;
      depth_q       <= '0;
      exh_q         <= 1'b0;
      count_q       <= '0;
      cand_q        <= '0;
      color_count_q <= 3'd3;
      done_q        <= 1'b0;
    end else begin
      if (cmd_i.load_row && row_ok) begin
        adj_q[vertex_i[IW-1:0]] <= neighbours_i[VERTICES-1:0];
      end
      vc_q    <= vc_d;
      d_q     <= d_d;
      depth_q <= depth_d;
      exh_q   <= exh_d;
      count_q <= count_d;
      cand_q  <= cand_d;
      if (cfg_valid_i) color_count_q <= cfg_data_i;
      done_q  <= respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (respond) begin
      priority if (cmd_i.place_fin) begin
        status_q   <= ST_FOUND;
        coloring_q <= packed_d;
      end else if (cmd_i.give_up || cmd_i.reply_exh) begin
        status_q   <= ST_EXHAUSTED;
        coloring_q <= '0;
      end else begin
        status_q   <= ST_ACK;
        coloring_q <= '0;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign coloring_o       = coloring_q;
  assign solution_count_o = count_q;

endmodule

// ===== rtl/graph_coloring_enumerator_top.sv =====
// Latency: load, restart, unknown words and a find once exhausted strobe done_o the cycle after.
// A find strobes done_o once its search ends; each vertex visit opens the vertex, then checks
// candidates, the one past the colour count included, in the single colour-trial step of the
// datapath (one candidate colour checked per cycle while in the trial state).
// Throughput: start is taken again in the cycle done_o strobes; the receiver cannot stall.
// Reset (rst_ni low, asynchronous): no edges, all vertices uncoloured, count zero, 3 colours.
`include "graph_coloring_enumerator_top_defines.svh"

module graph_coloring_enumerator_top
  import gce_pkg::*;
#(
  parameter int unsigned VERTICES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command word
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind_i,
  input  logic [2:0]           vertex_i,
  input  logic [7:0]           neighbours_i,
  // colour count register
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_data_i,
  // result word, one cycle per strobe
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ColoringW-1:0] coloring_o,
  output logic [CountW-1:0]    solution_count_o
);

  gce_cmd_t  cmd;
  gce_stat_t stat;

  // Writes should land only while idle; the block does not enforce it, and the register is always ready.
  assign cfg_ready_o = 1'b1;

  // Sequencer: decode the word, then walk the search one colour trial at a time.
  gce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Datapath: adjacency rows, vertex colours, depth, count and the result word.
  gce_dp #(
    .VERTICES (VERTICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .vertex_i         (vertex_i),
    .neighbours_i     (neighbours_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .coloring_o       (coloring_o),
    .solution_count_o (solution_count_o)
  );

  // A result only ever follows a word taken or a search under way.
  `GCE_ASSERT_NOW(a_done_has_cause, done_o, $past(busy) || $past(start), "result without a word")
  // The search has stopped by the time its result strobes.
  `GCE_ASSERT_NOW(a_done_idle, done_o, !busy, "result while still searching")
  // A colouring found means the count has moved off zero.
  `GCE_ASSERT_NOW(a_found_count, done_o && status_o == ST_FOUND, solution_count_o != '0, "zero count")
  // Only a found word carries a colouring.
  `GCE_ASSERT_NOW(a_coloring_zero, done_o && status_o != ST_FOUND, coloring_o == '0, "stray colour")

endmodule
